[rtl/rtcrf_pkg.sv]
// Package for the RTC register file with alarm.
// Holds the function and offset codes, write masks, item structs and BCD helper.
// No dependencies.
package rtcrf_pkg;

    localparam int RAM_WORDS_DEF = 13;
    localparam int BANK_REGS     = 13;

    // function codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_LOAD  = 2'd2;

    // special offsets
    localparam logic [3:0] OFF_MODE  = 4'd13;
    localparam logic [3:0] OFF_TEST  = 4'd14;
    localparam logic [3:0] OFF_RESET = 4'd15;

    // bank codes from the mode register
    localparam logic [1:0] BANK_TIME  = 2'd0;
    localparam logic [1:0] BANK_ALARM = 2'd1;
    localparam logic [1:0] BANK_RAM_L = 2'd2;
    localparam logic [1:0] BANK_RAM_H = 2'd3;

    localparam int ALARM_EN_BIT    = 2;
    localparam int RESET_ALARM_BIT = 0;
    localparam int LEAP_REG        = 11;
    localparam int CMP_FIRST       = 2;
    localparam int CMP_LAST        = 8;

    localparam logic [3:0] WMASK_TIME [16] = '{
        4'hf, 4'h7, 4'hf, 4'h7, 4'hf, 4'h3, 4'h7, 4'hf,
        4'h3, 4'hf, 4'h1, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf
    };
    localparam logic [3:0] WMASK_ALARM [16] = '{
        4'h0, 4'h0, 4'hf, 4'h7, 4'hf, 4'h3, 4'h7, 4'hf,
        4'h3, 4'h0, 4'h1, 4'h3, 4'h0, 4'hf, 4'hf, 4'hf
    };

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] offset;
        logic [3:0] data;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_req;

    typedef struct packed {
        logic [3:0] read_data;
        logic       alarm_line;
    } t_rsp;

    // Split a value below 128 into {tens, ones}; divide by ten via 205/2048.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  rem;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        rem  = v - 7'({3'b000, tens} * 7'd10);
        return {tens, rem[3:0]};
    endfunction

endpackage

[rtl/rtcrf_regs.sv]
// Register banks, RAM and alarm compare of the RTC register file.
// Depends on rtcrf_pkg.
module rtcrf_regs #(
    parameter int RAM_WORDS = rtcrf_pkg::RAM_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  rtcrf_pkg::t_req   i_req,
    output rtcrf_pkg::t_rsp   o_rsp
);

    localparam int RAM_AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
    localparam logic [4:0] RAM_LIM = 5'(RAM_WORDS);

    logic [3:0] r_time  [rtcrf_pkg::BANK_REGS];
    logic [3:0] n_time  [rtcrf_pkg::BANK_REGS];
    logic [3:0] r_alarm [rtcrf_pkg::BANK_REGS];
    logic [3:0] n_alarm [rtcrf_pkg::BANK_REGS];
    logic [7:0] r_ram   [RAM_WORDS];
    logic [7:0] n_ram   [RAM_WORDS];
    logic [3:0] r_mode, n_mode;
    logic       r_match_n, n_match_n;
    logic       r_line, n_line;

    logic [1:0]        bank;
    logic [3:0]        off;
    logic [RAM_AW-1:0] ram_idx;
    logic              ram_hit;
    logic [3:0]        rd;
    logic [7:0]        bcd_year, bcd_month, bcd_day, bcd_hour, bcd_min, bcd_sec;
    logic [3:0]        ld_time [rtcrf_pkg::BANK_REGS];
    logic              cmp_match, cmp_zero;

    assign bank    = r_mode[1:0];
    assign off     = i_req.offset;
    assign ram_idx = off[RAM_AW-1:0];
    assign ram_hit = ({1'b0, off} < RAM_LIM);

    assign bcd_year  = rtcrf_pkg::to_bcd(i_req.year);
    assign bcd_month = rtcrf_pkg::to_bcd({3'b000, i_req.month});
    assign bcd_day   = rtcrf_pkg::to_bcd({2'b00, i_req.day});
    assign bcd_hour  = rtcrf_pkg::to_bcd({2'b00, i_req.hour});
    assign bcd_min   = rtcrf_pkg::to_bcd({1'b0, i_req.minute});
    assign bcd_sec   = rtcrf_pkg::to_bcd({1'b0, i_req.second});

    always_comb begin
        ld_time[0]  = bcd_sec[3:0];
        ld_time[1]  = bcd_sec[7:4];
        ld_time[2]  = bcd_min[3:0];
        ld_time[3]  = bcd_min[7:4];
        ld_time[4]  = bcd_hour[3:0];
        ld_time[5]  = bcd_hour[7:4];
        ld_time[6]  = {1'b0, i_req.weekday};
        ld_time[7]  = bcd_day[3:0];
        ld_time[8]  = bcd_day[7:4];
        ld_time[9]  = bcd_month[3:0];
        ld_time[10] = bcd_month[7:4];
        ld_time[11] = bcd_year[3:0];
        ld_time[12] = bcd_year[7:4];
    end

    // compare the alarm against the freshly loaded time
    always_comb begin
        cmp_match = 1'b1;
        cmp_zero  = 1'b1;
        for (int i = rtcrf_pkg::CMP_FIRST; i <= rtcrf_pkg::CMP_LAST; i++) begin
            if (r_alarm[i] != 4'd0) cmp_zero = 1'b0;
            if (r_alarm[i] != ld_time[i]) cmp_match = 1'b0;
        end
    end

    always_comb begin
        n_time    = r_time;
        n_alarm   = r_alarm;
        n_ram     = r_ram;
        n_mode    = r_mode;
        n_match_n = r_match_n;
        n_line    = r_line;
        rd        = 4'd0;
        if (i_req_valid) begin
            case (i_req.func)
                rtcrf_pkg::FUNC_READ: begin
                    if (off == rtcrf_pkg::OFF_MODE) begin
                        rd = r_mode;
                    end else if (off == rtcrf_pkg::OFF_TEST || off == rtcrf_pkg::OFF_RESET) begin
                        rd = 4'd0;
                    end else begin
                        unique case (bank)
                            rtcrf_pkg::BANK_TIME:  rd = r_time[off];
                            rtcrf_pkg::BANK_ALARM: rd = r_alarm[off];
                            rtcrf_pkg::BANK_RAM_L: rd = ram_hit ? r_ram[ram_idx][3:0] : 4'd0;
                            default:               rd = ram_hit ? r_ram[ram_idx][7:4] : 4'd0;
                        endcase
                    end
                end
                rtcrf_pkg::FUNC_WRITE: begin
                    if (off == rtcrf_pkg::OFF_MODE) begin
                        n_mode = i_req.data;
                    end else if (off == rtcrf_pkg::OFF_RESET) begin
                        if (i_req.data[rtcrf_pkg::RESET_ALARM_BIT]) begin
                            for (int i = rtcrf_pkg::CMP_FIRST; i <= rtcrf_pkg::CMP_LAST; i++)
                                n_alarm[i] = 4'd0;
                        end
                    end else if (off != rtcrf_pkg::OFF_TEST) begin
                        unique case (bank)
                            rtcrf_pkg::BANK_TIME:
                                n_time[off] = i_req.data & rtcrf_pkg::WMASK_TIME[off];
                            rtcrf_pkg::BANK_ALARM:
                                n_alarm[off] = i_req.data & rtcrf_pkg::WMASK_ALARM[off];
                            rtcrf_pkg::BANK_RAM_L: begin
                                if (ram_hit)
                                    n_ram[ram_idx] = {r_ram[ram_idx][7:4], i_req.data};
                            end
                            default: begin
                                if (ram_hit)
                                    n_ram[ram_idx] = {i_req.data, r_ram[ram_idx][3:0]};
                            end
                        endcase
                    end
                end
                rtcrf_pkg::FUNC_LOAD: begin
                    n_time = ld_time;
                    n_alarm[rtcrf_pkg::LEAP_REG] = {2'b00, i_req.year[1:0]};
                    n_match_n = (cmp_match || (!r_match_n && cmp_zero)) ? 1'b0 : 1'b1;
                    n_line    = r_mode[rtcrf_pkg::ALARM_EN_BIT] ? n_match_n : 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.read_data  = rd;
    assign o_rsp.alarm_line = n_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '{default: '0};
            r_alarm   <= '{default: '0};
            r_ram     <= '{default: '0};
            r_mode    <= 4'd0;
            r_match_n <= 1'b1;
            r_line    <= 1'b1;
        end else begin
            r_time    <= n_time;
            r_alarm   <= n_alarm;
            r_ram     <= n_ram;
            r_mode    <= n_mode;
            r_match_n <= n_match_n;
            r_line    <= n_line;
        end
    end

endmodule

[rtl/rtc_register_file_with_alarm_top.sv]
// Top level of the RTC register file with alarm.
// Depends on rtcrf_pkg and rtcrf_regs.
//
// Usage: drive a word on the i_ ports and raise i_start. The word is taken
// at every rising edge with i_start high; o_busy is never raised, so one
// word per cycle is sustained. i_func selects a register read, a register
// write or a time load; writes and loads return a read value of zero.
// Flow: the word is registered at the accepting edge, processed against
// the register banks in the next cycle, and its result is registered at the
// following edge, where the register banks update as well: o_done marks
// each result for a single cycle, while o_read_data and o_alarm_out hold
// the result until the next result is shown.
// o_alarm_out is the active-low alarm line after the word and holds its
// value between results.
// Reset (synchronous, active low) clears all banks, the RAM and the mode
// register, and drives the alarm line high. The receiver cannot stall:
// each result is taken in the cycle it is shown.
module rtc_register_file_with_alarm_top #(
    parameter int RAM_WORDS = rtcrf_pkg::RAM_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_func,
    input  logic [3:0] i_offset,
    input  logic [3:0] i_data,
    input  logic [6:0] i_year,
    input  logic [3:0] i_month,
    input  logic [4:0] i_day,
    input  logic [2:0] i_weekday,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    input  logic [5:0] i_second,
    output logic       o_done,
    output logic [3:0] o_read_data,
    output logic       o_alarm_out
);

    rtcrf_pkg::t_req r_req;
    logic            r_req_valid;
    rtcrf_pkg::t_rsp rsp;
    logic            r_done;
    logic [3:0]      r_read_data;
    logic            r_alarm_out;

    assign o_busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req.func    <= i_func;
            r_req.offset  <= i_offset;
            r_req.data    <= i_data;
            r_req.year    <= i_year;
            r_req.month   <= i_month;
            r_req.day     <= i_day;
            r_req.weekday <= i_weekday;
            r_req.hour    <= i_hour;
            r_req.minute  <= i_minute;
            r_req.second  <= i_second;
        end
    end

    rtcrf_regs #(
        .RAM_WORDS (RAM_WORDS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_req_valid),
        .i_req       (r_req),
        .o_rsp       (rsp)
    );

    // result register; alarm line holds between results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_read_data <= 4'd0;
            r_alarm_out <= 1'b1;
        end else begin
            r_done <= r_req_valid;
            if (r_req_valid) begin
                r_read_data <= rsp.read_data;
                r_alarm_out <= rsp.alarm_line;
            end
        end
    end

    assign o_done      = r_done;
    assign o_read_data = r_read_data;
    assign o_alarm_out = r_alarm_out;

endmodule

[rtl/rtcrf_chk.sv]
// Port-level checker for the RTC register file with alarm, bound to the top.
// Depends on rtcrf_pkg and rtc_register_file_with_alarm_top.
module rtcrf_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic [1:0] i_func,
    input logic       o_done,
    input logic [3:0] o_read_data,
    input logic       o_alarm_out
);

    // every accepted word yields its result on o_done
    a_result_follows: assert property (@(posedge i_clk)
        ($past(i_rst_n, 2) && $past(i_rst_n) && $past(i_start && !o_busy, 2)) |-> o_done)
        else $error("accepted word produced no result");

    // no result without an accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 2))
        else $error("result without accepted word");

    // only reads return data
    a_zero_nonread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_func, 2) != rtcrf_pkg::FUNC_READ) |-> o_read_data == 4'd0)
        else $error("non-read returned data");

    // alarm line moves only on a time load
    a_alarm_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_func, 2) != rtcrf_pkg::FUNC_LOAD) |-> $stable(o_alarm_out))
        else $error("alarm line changed without time load");

endmodule

bind rtc_register_file_with_alarm_top rtcrf_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_func      (i_func),
    .o_done      (o_done),
    .o_read_data (o_read_data),
    .o_alarm_out (o_alarm_out)
);
